// ----- rtl/spe_pkg.sv -----
// Shared types and constants for the strided pattern extractor.
// Used by the front, queue, back and top level modules.
`default_nettype none
package spe_pkg;

  localparam int SPE_MAX_RES = 5;
  localparam int SPE_QDEPTH  = 2;
  localparam int SPE_CNT_W   = 3;

  typedef struct packed {
    logic [16:0] inner;
    logic [15:0] start;
    logic [16:0] stride;
    logic [16:0] rep;
    logic [9:0]  region;
  } spe_desc_t;

  typedef struct packed {
    logic [15:0] column;
    logic [16:0] inner;
    logic [15:0] start;
    logic [15:0] stride;
    logic [16:0] rep;
    logic [9:0]  region;
    logic        last;
  } spe_res_t;

  typedef struct packed {
    spe_res_t [SPE_MAX_RES-1:0] res;
    logic [SPE_CNT_W-1:0]       cnt;
  } spe_bundle_t;

endpackage
`default_nettype wire

// ----- rtl/strided_pattern_extractor_core.sv -----
// Top level of the strided pattern extractor: front, bundle queue, back.
// Depends on spe_pkg, spe_front, spe_queue and spe_back.
//
//  channel  | handshake         | payload
//  ---------+-------------------+-------------------------------------------
//  input    | push / full       | column_i region_i offset_i run_last_i
//           |                   | column_last_i
//  result   | pop / empty       | out_column_o inner_length_o start_offset_o
//           |                   | stride_o repeat_count_o out_region_o
//           |                   | last_of_column_o
//
// One request is taken per cycle while the two-entry bundle queue has room.
// Each request yields zero to five descriptors; the back end hands out one
// per cycle while pop is asserted.
// A result passes through the bundle queue and then the back-end bundle register.
// Reset clears all tracking state and the queue; no clearing pass follows.
`default_nettype none
module strided_pattern_extractor_core import spe_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [15:0] column_i,
  input  wire logic [9:0]  region_i,
  input  wire logic [15:0] offset_i,
  input  wire logic        run_last_i,
  input  wire logic        column_last_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [15:0]      out_column_o,
  output logic [16:0]      inner_length_o,
  output logic [15:0]      start_offset_o,
  output logic [15:0]      stride_o,
  output logic [16:0]      repeat_count_o,
  output logic [9:0]       out_region_o,
  output logic             last_of_column_o
);

  spe_bundle_t bundle, q_data;
  spe_res_t    res;
  logic        take, q_full, q_empty, q_rd;

  assign full = q_full;
  assign take = push && !q_full;

  spe_front u_front (
    .clk_i,
    .rst_ni,
    .take_i        (take),
    .column_i,
    .region_i,
    .offset_i,
    .run_last_i,
    .column_last_i,
    .bundle_o      (bundle)
  );

  spe_queue u_queue (
    .clk_i,
    .rst_ni,
    .wr_i    (take && bundle.cnt != '0),
    .wdata_i (bundle),
    .full_o  (q_full),
    .rd_i    (q_rd),
    .rdata_o (q_data),
    .empty_o (q_empty)
  );

  spe_back u_back (
    .clk_i,
    .rst_ni,
    .q_empty_i (q_empty),
    .q_data_i  (q_data),
    .q_rd_o    (q_rd),
    .pop_i     (pop),
    .empty_o   (empty),
    .res_o     (res)
  );

  assign out_column_o     = res.column;
  assign inner_length_o   = res.inner;
  assign start_offset_o   = res.start;
  assign stride_o         = res.stride;
  assign repeat_count_o   = res.rep;
  assign out_region_o     = res.region;
  assign last_of_column_o = res.last;

endmodule
`default_nettype wire

// ----- rtl/spe_front.sv -----
// Front end: tracks runs per column and classifies each request into
// the descriptors it completes. Depends on spe_pkg.
`default_nettype none
module spe_front import spe_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        take_i,
  input  wire logic [15:0] column_i,
  input  wire logic [9:0]  region_i,
  input  wire logic [15:0] offset_i,
  input  wire logic        run_last_i,
  input  wire logic        column_last_i,
  output spe_bundle_t      bundle_o
);

  typedef struct packed {
    logic        building;
    logic        run_ended;
    logic [15:0] run_ref;
    logic        pend_valid;
    spe_desc_t   pend;
    logic [15:0] column;
    spe_bundle_t bun;
  } spe_work_t;

  function automatic spe_work_t emit(spe_work_t w, spe_desc_t d, logic last);
    spe_res_t r;
    r.column = w.column;
    r.inner  = d.inner;
    r.start  = d.start;
    r.stride = (d.stride == 17'd0) ? 16'd1 : d.stride[15:0];
    r.rep    = d.rep;
    r.region = d.region;
    r.last   = last;
    if (w.bun.cnt < SPE_CNT_W'(SPE_MAX_RES)) begin
      for (int i = 0; i < SPE_MAX_RES; i++) begin
        if (w.bun.cnt == SPE_CNT_W'(i)) w.bun.res[i] = r;
      end
      w.bun.cnt = w.bun.cnt + SPE_CNT_W'(1);
    end
    return w;
  endfunction

  function automatic spe_work_t open_new(spe_work_t w, logic [16:0] inner,
                                         logic [15:0] start, logic [16:0] rep,
                                         logic [9:0] region);
    if (w.pend_valid) w = emit(w, w.pend, 1'b0);
    w.pend.inner  = inner;
    w.pend.start  = start;
    w.pend.stride = 17'd0;
    w.pend.rep    = rep;
    w.pend.region = region;
    w.pend_valid  = 1'b1;
    return w;
  endfunction

  function automatic spe_work_t track(spe_work_t w, logic found, logic [9:0] cur_region,
                                      logic [9:0] prev_region, logic [16:0] eoff,
                                      logic region_end);
    logic [16:0] len;
    logic [16:0] n;
    if (found && !w.building) begin
      w.run_ref   = eoff[15:0];
      w           = open_new(w, 17'd0, eoff[15:0], 17'd0, cur_region);
      w.run_ended = 1'b0;
      w.building  = 1'b1;
    end
    if (w.building) begin
      len = eoff - {1'b0, w.run_ref};
      if (!w.run_ended && !found) begin
        if (w.pend.inner != 17'd0) begin
          if (w.pend.inner != len)
            w = open_new(w, len, w.run_ref, 17'd0, region_end ? prev_region : cur_region);
        end else begin
          w.pend.inner = len;
        end
        w.run_ended = 1'b1;
        w.pend.rep  = w.pend.rep + 17'd1;
      end
      if (found && w.run_ended) begin
        w.run_ended = 1'b0;
        if (w.pend.stride != 17'd0) begin
          if (w.pend.stride != len) w = open_new(w, 17'd0, eoff[15:0], 17'd0, cur_region);
        end else begin
          w.pend.stride = len;
        end
        w.run_ref = eoff[15:0];
        len       = 17'd0;
      end
      if (region_end) begin
        if (!w.run_ended) begin
          n = len + 17'd1;
          if (w.pend.inner != 17'd0) begin
            if (w.pend.inner == n) w.pend.rep = w.pend.rep + 17'd1;
            else w = open_new(w, n, w.run_ref, 17'd1, cur_region);
          end
          if (w.pend.inner == 17'd0) begin
            w.pend.inner = n;
            w.pend.rep   = 17'd1;
          end
        end
        w.building = 1'b0;
      end
    end
    return w;
  endfunction

  logic        building_q, building_d;
  logic        run_ended_q, run_ended_d;
  logic [15:0] run_ref_q, run_ref_d;
  logic [9:0]  prior_region_q;
  logic [15:0] prior_offset_q;
  logic [15:0] column_q, column_d;
  logic        pend_valid_q, pend_valid_d;
  spe_desc_t   pend_q, pend_d;

  always_comb begin
    spe_work_t   w;
    logic        run_last;
    logic        new_region;
    logic [16:0] next_off;
    run_last     = run_last_i | column_last_i;
    w.building   = building_q;
    w.run_ended  = run_ended_q;
    w.run_ref    = run_ref_q;
    w.pend_valid = pend_valid_q;
    w.pend       = pend_q;
    w.column     = column_q;
    w.bun        = '0;
    new_region   = region_i != prior_region_q;
    next_off     = {1'b0, prior_offset_q} + 17'd1;

    if (w.pend_valid && column_i != w.column) begin
      w            = emit(w, w.pend, 1'b1);
      w.pend_valid = 1'b0;
    end
    if (!w.pend_valid) begin
      w.column      = column_i;
      w.pend.inner  = {16'd0, run_last};
      w.pend.start  = offset_i;
      w.pend.stride = 17'd0;
      w.pend.rep    = {16'd0, run_last};
      w.pend.region = region_i;
      w.pend_valid  = 1'b1;
      w.run_ended   = 1'b0;
      w.run_ref     = offset_i;
      w.building    = !run_last;
    end else begin
      if (new_region || {1'b0, offset_i} != next_off) begin
        w = track(w, 1'b0, region_i, prior_region_q, next_off, new_region);
        if (!new_region)
          w = track(w, 1'b0, region_i, prior_region_q, {1'b0, offset_i} - 17'd1, 1'b0);
      end
      w = track(w, 1'b1, region_i, prior_region_q, {1'b0, offset_i}, column_last_i);
    end
    if (column_last_i) begin
      w            = emit(w, w.pend, 1'b1);
      w.pend_valid = 1'b0;
      w.building   = 1'b0;
      w.run_ended  = 1'b0;
    end

    building_d   = w.building;
    run_ended_d  = w.run_ended;
    run_ref_d    = w.run_ref;
    column_d     = w.column;
    pend_valid_d = w.pend_valid;
    pend_d       = w.pend;
    bundle_o     = w.bun;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      building_q     <= 1'b0;
      run_ended_q    <= 1'b0;
      run_ref_q      <= '0;
      prior_region_q <= '0;
      prior_offset_q <= '0;
      column_q       <= '0;
      pend_valid_q   <= 1'b0;
      pend_q         <= '0;
    end else if (take_i) begin
      building_q     <= building_d;
      run_ended_q    <= run_ended_d;
      run_ref_q      <= run_ref_d;
      prior_region_q <= region_i;
      prior_offset_q <= offset_i;
      column_q       <= column_d;
      pend_valid_q   <= pend_valid_d;
      pend_q         <= pend_d;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/spe_queue.sv -----
// Short queue of descriptor bundles between front and back.
// Depends on spe_pkg.
`default_nettype none
module spe_queue import spe_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  wr_i,
  input  wire spe_bundle_t wdata_i,
  output logic       full_o,
  input  wire logic  rd_i,
  output spe_bundle_t rdata_o,
  output logic       empty_o
);

  localparam int PtrW = $clog2(SPE_QDEPTH);
  localparam int CntW = $clog2(SPE_QDEPTH + 1);

  spe_bundle_t          mem_q [SPE_QDEPTH];
  logic [PtrW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]      count_q;
  logic                 do_wr, do_rd;

  assign full_o  = count_q == CntW'(SPE_QDEPTH);
  assign empty_o = count_q == '0;
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wr_ptr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) wr_ptr_q <= (wr_ptr_q == PtrW'(SPE_QDEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      if (do_rd) rd_ptr_q <= (rd_ptr_q == PtrW'(SPE_QDEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      if (do_wr && !do_rd) count_q <= count_q + CntW'(1);
      else if (do_rd && !do_wr) count_q <= count_q - CntW'(1);
    end
  end

endmodule
`default_nettype wire

// ----- rtl/spe_back.sv -----
// Back end: holds one bundle and hands out its descriptors one per pop.
// Depends on spe_pkg.
`default_nettype none
module spe_back import spe_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   q_empty_i,
  input  wire spe_bundle_t q_data_i,
  output logic        q_rd_o,
  input  wire logic   pop_i,
  output logic        empty_o,
  output spe_res_t    res_o
);

  spe_bundle_t          bun_q;
  logic [SPE_CNT_W-1:0] idx_q;
  logic                 valid_q;
  logic                 at_last;

  assign at_last = idx_q == bun_q.cnt - SPE_CNT_W'(1);
  assign empty_o = !valid_q;
  assign q_rd_o  = !q_empty_i && (!valid_q || (pop_i && at_last));

  always_comb begin
    res_o = bun_q.res[0];
    for (int i = 1; i < SPE_MAX_RES; i++) begin
      if (idx_q == SPE_CNT_W'(i)) res_o = bun_q.res[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_rd_o) bun_q <= q_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (q_rd_o) begin
      valid_q <= 1'b1;
      idx_q   <= '0;
    end else if (pop_i && valid_q) begin
      if (at_last) valid_q <= 1'b0;
      else idx_q <= idx_q + SPE_CNT_W'(1);
    end
  end

endmodule
`default_nettype wire
